/* sv/hlvn_pkg.sv */
// ----------------------------------------------------------------------------
// hlvn_pkg
// Shared constants, payload types and the blend function of the hashed
// lattice value noise pipeline.
// ----------------------------------------------------------------------------
package hlvn_pkg;

  // Hash constants
  localparam logic [31:0] HASH_MUL_X   = 32'd1664525;
  localparam logic [31:0] HASH_MUL_Y   = 32'd1013904223;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
  localparam int          HASH_SHIFT   = 13;

  // Widths
  localparam int COORD_W = 32;
  localparam int FRAC_W  = 17;
  localparam int VAL_W   = 24;
  localparam int NOISE_W = 21;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 2;
  localparam int CORNERS = 8;

  // Total register stages from input to result
  localparam int PIPE_DEPTH = 7;

  // Output saturation bounds
  localparam logic signed [VAL_W-1:0] OUT_MAX = 24'sd1048575;
  localparam logic signed [VAL_W-1:0] OUT_MIN = -24'sd1048576;

  // Per-item fractions and mode, carried along the pipe
  typedef struct packed {
    logic                     mode;
    logic signed [FRAC_W-1:0] fx;
    logic signed [FRAC_W-1:0] fy;
    logic signed [FRAC_W-1:0] fz;
  } frac_t;

  // Lattice cell of one item after the coordinate split
  typedef struct packed {
    frac_t       frac;
    logic [31:0] x0;
    logic [31:0] y0;
    logic [31:0] s0;
    logic [31:0] s1;
  } lattice_t;

  // Hashed corner values, index bit 0 = x, bit 1 = y, bit 2 = z
  typedef struct packed {
    frac_t                  frac;
    logic [CORNERS-1:0][15:0] corner;
  } corners_t;

  // a + round((b - a) * t / 2^16), ties toward plus infinity
  function automatic logic signed [VAL_W-1:0] blend(
    input logic signed [VAL_W-1:0]  a,
    input logic signed [VAL_W-1:0]  b,
    input logic signed [FRAC_W-1:0] t
  );
    logic signed [VAL_W:0]              diff;
    logic signed [VAL_W+FRAC_W:0]       prod;
    logic signed [VAL_W+FRAC_W:0]       step;
    diff = {b[VAL_W-1], b} - {a[VAL_W-1], a};
    prod = diff * t;
    step = (prod + (VAL_W + FRAC_W + 1)'(32768)) >>> 16;
    return a + step[VAL_W-1:0];
  endfunction

endpackage

/* sv/hlvn_if.sv */
// ----------------------------------------------------------------------------
// hlvn_if
// Valid/ready channels of the noise unit: coordinate items in, noise out.
// ----------------------------------------------------------------------------
interface hlvn_in_if
  import hlvn_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, mode, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, mode, coord_x, coord_y, coord_z, output ready);
endinterface

interface hlvn_out_if
  import hlvn_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

/* sv/hashed_lattice_value_noise_unit.sv */
// ----------------------------------------------------------------------------
// hashed_lattice_value_noise_unit
// Hashed lattice value noise, 2D bilinear or 3D trilinear, in fixed point.
// ----------------------------------------------------------------------------
// The unit takes one coordinate item per clock unless stalled and returns
// one noise sample per item, in order: one stage splits the coordinates,
// three stages hash the eight cell corners (axis products, corner sums,
// mixing multiply) and three stages blend along x, y and z. Each stage
// advances when it is empty or the stage after it moves, so bubbles close
// up on an output stall, with up to seven items in flight. The user must
// write the 2D seed over the APB port only while the unit is idle (unchecked).
// ----------------------------------------------------------------------------
module hashed_lattice_value_noise_unit import hlvn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  hlvn_in_if.sink           in_i,
  hlvn_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

  logic [31:0] seed_q;
  logic        cfg_wr;

  logic     split_valid, split_ready;
  lattice_t split_data;
  logic     hash_valid, hash_ready;
  corners_t hash_data;

  // Configuration: all byte offsets of the single word map to the seed
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == paddr);
  assign prdata = seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_wr) begin
      seed_q <= pwdata;
    end
  end

  // Coordinate split
  hlvn_split u_split (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .mode_i    (in_i.mode),
    .coord_x_i (in_i.coord_x),
    .coord_y_i (in_i.coord_y),
    .coord_z_i (in_i.coord_z),
    .seed_i    (seed_q),
    .valid_o   (split_valid),
    .ready_i   (split_ready),
    .data_o    (split_data)
  );

  // Corner hashing
  hlvn_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .data_i  (split_data),
    .valid_o (hash_valid),
    .ready_i (hash_ready),
    .data_o  (hash_data)
  );

  // Interpolation and saturation
  hlvn_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hash_valid),
    .ready_o (hash_ready),
    .data_i  (hash_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .noise_o (out_o.noise_value)
  );

  // Track items in flight for the checks below
  logic [CNT_W-1:0] inflight_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - CNT_W'(1);
    end
  end

  // Never more items held than the pipe has stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  // No result without an item in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == '0) |-> !out_o.valid)
    else $error("result shown with no item in flight");

  // A full, stalled pipe takes no further item
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready && inflight_q == CNT_W'(PIPE_DEPTH)) |-> !in_i.ready)
    else $error("item accepted into a full stalled pipeline");

  // A seed write takes effect at the next edge
  a_seed_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (seed_q == $past(pwdata)))
    else $error("seed register not updated by write");

endmodule

/* sv/hlvn_split.sv */
// ----------------------------------------------------------------------------
// hlvn_split
// Split each Q16.16 coordinate into a truncated integer part and a signed
// fraction, and pick the hash seeds of the two z planes. One register stage.
// ----------------------------------------------------------------------------
module hlvn_split import hlvn_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic                      mode_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic [31:0]               seed_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output lattice_t                  data_o
);

  // Integer part truncated toward zero: negative values with a fraction
  // round up by one
  function automatic logic [31:0] int_part(input logic [COORD_W-1:0] c);
    logic [31:0] hi;
    hi = {{16{c[31]}}, c[31:16]};
    if (c[31] && (c[15:0] != 16'd0)) begin
      return hi + 32'd1;
    end
    return hi;
  endfunction

  // Fraction is coordinate minus integer part, negative for negative inputs with a nonzero fraction
  function automatic logic signed [FRAC_W-1:0] frac_part(input logic [COORD_W-1:0] c);
    return {c[31] && (c[15:0] != 16'd0), c[15:0]};
  endfunction

  logic     en;
  logic     valid_q;
  lattice_t data_d, data_q;
  logic [31:0] zi;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  // Split coordinates and select seeds
  always_comb begin
    zi               = int_part(coord_z_i);
    data_d.frac.mode = mode_i;
    data_d.frac.fx   = frac_part(coord_x_i);
    data_d.frac.fy   = frac_part(coord_y_i);
    data_d.frac.fz   = frac_part(coord_z_i);
    data_d.x0        = int_part(coord_x_i);
    data_d.y0        = int_part(coord_y_i);
    data_d.s0        = mode_i ? zi : seed_i;
    data_d.s1        = mode_i ? (zi + 32'd1) : seed_i;
  end

  // Hold stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  // Load payload on advance
  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/hlvn_hash.sv */
// ----------------------------------------------------------------------------
// hlvn_hash
// Hash the eight lattice corners of a cell in three stages: axis products,
// corner sums with shift-xor, and the final mixing multiply.
// ----------------------------------------------------------------------------
module hlvn_hash import hlvn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  lattice_t data_i,
  output logic     valid_o,
  input  logic     ready_i,
  output corners_t data_o
);

  localparam int STAGES = 3;

  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] en;

  // Stage a: axis products
  frac_t       frac_a_q;
  logic [31:0] ax_q, by_q, s0_q, s1_q;
  // Stage b: mixed corner sums
  frac_t                    frac_b_q;
  logic [CORNERS-1:0][31:0] mix_d, mix_q;
  // Stage c: corner values
  corners_t                 out_q;
  logic [CORNERS-1:0][15:0] corner_d;

  // Advance a stage when it is empty or the next one moves
  assign en[STAGES-1] = !valid_q[STAGES-1] || ready_i;
  for (genvar k = 0; k < STAGES - 1; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end
  assign ready_o = en[0];

  // Corner sums, shift-xor and mixing multiply
  for (genvar c = 0; c < CORNERS; c++) begin : g_corner
    localparam logic [2:0] IDX = 3'(c);
    logic [31:0] sum;
    logic [31:0] prod;
    assign sum = (ax_q + (IDX[0] ? HASH_MUL_X : 32'd0))
               + (by_q + (IDX[1] ? HASH_MUL_Y : 32'd0))
               + (IDX[2] ? s1_q : s0_q);
    assign mix_d[c]    = sum ^ (sum >> HASH_SHIFT);
    assign prod        = mix_q[c] * HASH_MUL_MIX;
    assign corner_d[c] = prod[31:16];
  end

  // Hold stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  // Load payload registers on advance
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      frac_a_q <= data_i.frac;
      ax_q     <= data_i.x0 * HASH_MUL_X;
      by_q     <= data_i.y0 * HASH_MUL_Y;
      s0_q     <= data_i.s0;
      s1_q     <= data_i.s1;
    end
    if (en[1]) begin
      frac_b_q <= frac_a_q;
      mix_q    <= mix_d;
    end
    if (en[2]) begin
      out_q.frac   <= frac_b_q;
      out_q.corner <= corner_d;
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign data_o  = out_q;

endmodule

/* sv/hlvn_blend.sv */
// ----------------------------------------------------------------------------
// hlvn_blend
// Blend the corner values along x, then y, then z in 3D mode, and saturate
// the result to signed Q5.16. Three register stages.
// ----------------------------------------------------------------------------
module hlvn_blend import hlvn_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  corners_t                  data_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic signed [NOISE_W-1:0] noise_o
);

  localparam int STAGES = 3;

  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] en;

  frac_t                          frac_x_q, frac_y_q;
  logic signed [3:0][VAL_W-1:0]   row_d, row_q;
  logic signed [1:0][VAL_W-1:0]   plane_d, plane_q;
  logic signed [VAL_W-1:0]        res;
  logic signed [NOISE_W-1:0]      noise_d, noise_q;

  assign en[STAGES-1] = !valid_q[STAGES-1] || ready_i;
  for (genvar k = 0; k < STAGES - 1; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end
  assign ready_o = en[0];

  // Blend along x: one row per (y, z) pair
  for (genvar r = 0; r < 4; r++) begin : g_row
    assign row_d[r] = blend({8'd0, data_i.corner[2*r]}, {8'd0, data_i.corner[2*r+1]},
                            data_i.frac.fx);
  end

  // Blend along y: one plane per z
  for (genvar p = 0; p < 2; p++) begin : g_plane
    assign plane_d[p] = blend(row_q[2*p], row_q[2*p+1], frac_x_q.fy);
  end

  // Blend along z in 3D mode and saturate
  always_comb begin
    res = frac_y_q.mode ? blend(plane_q[0], plane_q[1], frac_y_q.fz) : plane_q[0];
    if (res > OUT_MAX) begin
      noise_d = OUT_MAX[NOISE_W-1:0];
    end else if (res < OUT_MIN) begin
      noise_d = OUT_MIN[NOISE_W-1:0];
    end else begin
      noise_d = res[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      frac_x_q <= data_i.frac;
      row_q    <= row_d;
    end
    if (en[1]) begin
      frac_y_q <= frac_x_q;
      plane_q  <= plane_d;
    end
    if (en[2]) begin
      noise_q <= noise_d;
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign noise_o = noise_q;

endmodule
